// File: rtl/pqhs_pkg.sv
// Shared constants and types for the play queue and history stack.
package pqhs_pkg;

    localparam int QUEUE_DEPTH_DEF   = 128;
    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int ID_WIDTH_DEF      = 16;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_NEXT = 2'd1,
        KIND_PREV = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_QFULL  = 2'd1,
        ST_QEMPTY = 2'd2,
        ST_HEMPTY = 2'd3
    } status_t;

endpackage

// File: rtl/pqhs_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module pqhs_ram
    import pqhs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = ID_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/play_queue_history_stack.sv
// Top level of the play queue and history stack: pointer control and two RAMs.
//
// A command is transferred at a rising clock edge where start is high and busy
// is low; kind selects add, play next or play previous, and item_id is the
// identifier to add. Every command yields exactly one result, shown on
// result_id, status and not_recorded for one cycle while done is high.
// The result appears in the cycle after the transfer, and busy is high during
// that cycle, so no new command is taken while a result is shown. Busy is
// needed because the queue and history RAMs have registered reads: a played
// identifier is read from the queue RAM in the transfer cycle and written into
// the history RAM in the result cycle.
// The receiver cannot stall; a result is valid for its single done cycle only.
// Reset clears the head, tail and both counts, and the block is idle after
// it. The RAM contents are not cleared and need no clearing pass, since an
// entry is always written before it is read.
module play_queue_history_stack
    import pqhs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int ID_WIDTH      = ID_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic [ID_WIDTH-1:0] item_id,
    output logic                done,
    output logic [ID_WIDTH-1:0] result_id,
    output logic [1:0]          status,
    output logic                not_recorded
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    logic [QAW-1:0] q_head_reg, q_head_next;
    logic [QAW-1:0] q_tail_reg, q_tail_next;
    logic [QCW-1:0] q_count_reg, q_count_next;
    logic [HCW-1:0] h_count_reg, h_count_next;

    logic           pend_reg, pend_next;
    logic [1:0]     pend_kind_reg, pend_kind_next;
    status_t        pend_status_reg, pend_status_next;
    logic           pend_lost_reg, pend_lost_next;
    logic [HAW-1:0] pend_haddr_reg, pend_haddr_next;

    logic                accept;
    logic                q_we, q_re, h_we, h_re;
    logic [HAW-1:0]      h_raddr;
    logic [HCW-1:0]      h_count_dec;
    logic [ID_WIDTH-1:0] q_rdata, h_rdata;
    logic                q_full, q_empty, h_full, h_empty;

    assign accept      = start && !busy;
    assign q_full      = (q_count_reg == QCW'(QUEUE_DEPTH));
    assign q_empty     = (q_count_reg == '0);
    assign h_full      = (h_count_reg == HCW'(HISTORY_DEPTH));
    assign h_empty     = (h_count_reg == '0);
    assign h_count_dec = h_count_reg - 1'b1;

    always_comb
    begin
        q_head_next      = q_head_reg;
        q_tail_next      = q_tail_reg;
        q_count_next     = q_count_reg;
        h_count_next     = h_count_reg;
        pend_next        = 1'b0;
        pend_kind_next   = pend_kind_reg;
        pend_status_next = pend_status_reg;
        pend_lost_next   = pend_lost_reg;
        pend_haddr_next  = pend_haddr_reg;
        q_we             = 1'b0;
        q_re             = 1'b0;
        h_re             = 1'b0;
        h_raddr          = h_count_dec[HAW-1:0];
        if (accept)
        begin
            pend_next        = 1'b1;
            pend_kind_next   = kind;
            pend_status_next = ST_OK;
            pend_lost_next   = 1'b0;
            pend_haddr_next  = h_count_reg[HAW-1:0];
            case (kind)
                KIND_ADD:
                begin
                    if (q_full)
                    begin
                        pend_status_next = ST_QFULL;
                    end
                    else
                    begin
                        q_we         = 1'b1;
                        q_tail_next  = (q_tail_reg == QAW'(QUEUE_DEPTH - 1)) ?
                                       '0 : q_tail_reg + 1'b1;
                        q_count_next = q_count_reg + 1'b1;
                    end
                end
                KIND_NEXT:
                begin
                    if (q_empty)
                    begin
                        pend_status_next = ST_QEMPTY;
                    end
                    else
                    begin
                        q_re         = 1'b1;
                        q_head_next  = (q_head_reg == QAW'(QUEUE_DEPTH - 1)) ?
                                       '0 : q_head_reg + 1'b1;
                        q_count_next = q_count_reg - 1'b1;
                        if (h_full)
                        begin
                            pend_lost_next = 1'b1;
                        end
                        else
                        begin
                            h_count_next = h_count_reg + 1'b1;
                        end
                    end
                end
                KIND_PREV:
                begin
                    if (h_empty)
                    begin
                        pend_status_next = ST_HEMPTY;
                    end
                    else
                    begin
                        h_re         = 1'b1;
                        h_count_next = h_count_dec;
                    end
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
            h_count_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            q_head_reg  <= q_head_next;
            q_tail_reg  <= q_tail_next;
            q_count_reg <= q_count_next;
            h_count_reg <= h_count_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg   <= pend_kind_next;
        pend_status_reg <= pend_status_next;
        pend_lost_reg   <= pend_lost_next;
        pend_haddr_reg  <= pend_haddr_next;
    end

    assign h_we = pend_reg && (pend_kind_reg == KIND_NEXT) &&
                  (pend_status_reg == ST_OK) && !pend_lost_reg;

    pqhs_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_tail_reg),
        .wdata (item_id),
        .re    (q_re),
        .raddr (q_head_reg),
        .rdata (q_rdata)
    );

    pqhs_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_history_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (pend_haddr_reg),
        .wdata (q_rdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    always_comb
    begin
        result_id = '0;
        if (pend_reg && (pend_status_reg == ST_OK))
        begin
            if (pend_kind_reg == KIND_NEXT)
            begin
                result_id = q_rdata;
            end
            else if (pend_kind_reg == KIND_PREV)
            begin
                result_id = h_rdata;
            end
        end
    end

    assign busy         = pend_reg;
    assign done         = pend_reg;
    assign status       = pend_reg ? pend_status_reg : ST_OK;
    assign not_recorded = pend_reg && pend_lost_reg;

    a_done_follows_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("Result strobe without a preceding command transfer.");

    a_error_zero_id: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (result_id == '0))
        else $error("Nonzero identifier returned with an error status.");

    a_lost_only_on_play: assert property (
        @(posedge clk) disable iff (!rst_n)
        not_recorded |-> (done && (status == ST_OK) && (pend_kind_reg == KIND_NEXT)))
        else $error("Not-recorded flag set outside a successful play next.");

    a_queue_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_count_reg <= QCW'(QUEUE_DEPTH)) && (h_count_reg <= HCW'(HISTORY_DEPTH)))
        else $error("Queue or history count exceeds its depth.");

    a_pointers_meet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (q_head_reg == q_tail_reg))
        else $error("Head and tail disagree with an empty or full queue.");

    a_history_write_target: assert property (
        @(posedge clk) disable iff (!rst_n)
        h_we |-> (h_count_reg == (HCW'(pend_haddr_reg) + 1'b1)))
        else $error("History write address does not match the pushed count.");

endmodule
